FILE: src/threshold_rule_trigger_engine_assert.svh
// assertion macros for the rule trigger engine
`ifndef THRESHOLD_RULE_TRIGGER_ENGINE_ASSERT_SVH
`define THRESHOLD_RULE_TRIGGER_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TRTE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TRTE_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define TRTE_ASSERT(label, clk, rst_n, prop)
`define TRTE_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: src/trte_pkg.sv
// ----------------------------------------------------------------------------
// trte_pkg
// types and constants of the threshold rule trigger engine
// ----------------------------------------------------------------------------
package trte_pkg;
  localparam int unsigned RuleSlots = 16;
  localparam int unsigned IdxW = $clog2(RuleSlots);
  localparam int unsigned CntW = $clog2(RuleSlots + 1);
  localparam logic [11:0] SecondsPerHour = 12'd3600;
  localparam logic [4:0] LastHour = 5'd23;

  localparam logic [1:0] OpMeasure = 2'd0;
  localparam logic [1:0] OpAdd     = 2'd1;
  localparam logic [1:0] OpRemove  = 2'd2;
  localparam logic [1:0] OpUnused  = 2'd3;

  localparam logic [1:0] KindCommand = 2'd0;
  localparam logic [1:0] KindEcho    = 2'd1;
  localparam logic [1:0] KindStatus  = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StInvalid  = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StDup      = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;

  localparam logic CfgMinRest = 1'b0;
  localparam logic CfgMaxRest = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  sensor_id;
    logic signed [15:0] value;
    logic [31:0] now_seconds;
    logic [4:0]  local_hour;
    logic        route_ready;
    logic [7:0]  command_id;
    logic        compare_mode;
    logic [4:0]  start_hour;
    logic [4:0]  end_hour;
    logic [7:0]  rest_hours;
    logic [15:0] duration;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_command_id;
    logic [15:0] out_duration;
    logic [7:0]  out_sensor_id;
    logic signed [15:0] out_value;
    logic [2:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0]  sensor;
    logic [15:0] thr;
    logic        cmp;
    logic [4:0]  sh;
    logic [4:0]  eh;
    logic [7:0]  cmd;
    logic [7:0]  rest;
    logic [15:0] dur;
  } rule_t;
endpackage

FILE: src/trte_rest_mul.sv
// ----------------------------------------------------------------------------
// trte_rest_mul
// shift-add multiply of rest hours by seconds per hour, one bit a cycle
// ----------------------------------------------------------------------------
module trte_rest_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  hours_i,
  output logic        done_o,
  output logic [19:0] secs_o
);
  import trte_pkg::*;

  logic [7:0]  hrs_q, hrs_d;
  logic [19:0] acc_q, acc_d;
  logic [19:0] mcand_q, mcand_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;

  always_comb begin
    hrs_d = hrs_q;
    acc_d = acc_q;
    mcand_d = mcand_q;
    cnt_d = cnt_q;
    run_d = run_q;
    done_d = 1'b0;
    if (start_i) begin
      hrs_d = hours_i;
      acc_d = '0;
      mcand_d = {8'd0, SecondsPerHour};
      cnt_d = 4'd8;
      run_d = 1'b1;
    end else if (run_q) begin
      if (hrs_q[0]) acc_d = acc_q + mcand_q;
      hrs_d = hrs_q >> 1;
      mcand_d = mcand_q << 1;
      cnt_d = cnt_q - 4'd1;
      // product is complete in acc_q the cycle after the last step
      if (cnt_q == 4'd1) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hrs_q <= hrs_d;
    acc_q <= acc_d;
    mcand_q <= mcand_d;
  end

  assign done_o = done_q;
  assign secs_o = acc_q;
endmodule

FILE: src/threshold_rule_trigger_engine.sv
// ----------------------------------------------------------------------------
// threshold_rule_trigger_engine
// rule table with per-rule cooldown, walked one entry per step
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the request is done, and no new request is taken meanwhile. Results
// come at most one per cycle on res_o with valid_o high and cannot be held
// off; the final result of a request shows on valid_o in the first cycle in
// which busy is low again. The table is walked through a single read port,
// entry by entry: a read state, then a check state. Add and remove walk the
// whole table; a remove that finds its rule then moves the last entry into
// its slot, and both give one status result. With an empty table a request
// goes straight to the done state. A measure leaves an entry that fails its
// sensor, hour, threshold or ready check after the check state; an entry that
// passes them also runs a shift-add multiply for its rest time, then the rest
// check state, then the echo state to move on, which after the first command
// is taken once more for the echo of the measure. The walk ends in the echo state.
// Rule table memory contents are undefined after reset; only entries below the
// rule count are used.
module threshold_rule_trigger_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  trte_pkg::req_t    req_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  output logic              valid_o,
  output trte_pkg::res_t    res_o
);
  import trte_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_READ  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_REST  = 9'b000010000,
    S_ECHO  = 9'b000100000,
    S_MOVE  = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  rule_t       rules_mem [RuleSlots];
  logic [31:0] time_mem  [RuleSlots];

  req_t          req_q, req_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] found_q, found_d;
  logic          fnd_q, fnd_d;
  logic          echoed_q, echoed_d;
  logic          pend_q, pend_d;
  logic [7:0]    min_q, max_q;
  logic [IdxW-1:0] raddr;
  rule_t         rd_rule_q;
  logic [31:0]   rd_time_q;
  logic          we_rule, we_time;
  logic [IdxW-1:0] waddr;
  rule_t         wrule;
  logic [31:0]   wtime;
  logic          valid_d;
  res_t          res_d;
  res_t          hold_q, hold_d;
  logic          hold_v_q, hold_v_d;
  logic          mul_start, mul_done;
  logic [19:0]   mul_secs;

  rule_t  req_rule;
  logic   in_win, met, last_rule, rest_over;
  logic [31:0] elapsed;

  trte_rest_mul u_rest_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .hours_i(rd_rule_q.rest),
    .done_o (mul_done),
    .secs_o (mul_secs)
  );

  assign req_rule = '{sensor: req_q.sensor_id, thr: req_q.value, cmp: req_q.compare_mode,
                      sh: req_q.start_hour, eh: req_q.end_hour, cmd: req_q.command_id,
                      rest: req_q.rest_hours, dur: req_q.duration};

  always_comb begin
    if (rd_rule_q.sh <= rd_rule_q.eh)
      in_win = req_q.local_hour >= rd_rule_q.sh && req_q.local_hour <= rd_rule_q.eh;
    else
      in_win = req_q.local_hour >= rd_rule_q.sh || req_q.local_hour <= rd_rule_q.eh;
    if (rd_rule_q.cmp)
      met = $signed(req_q.value) >= $signed(rd_rule_q.thr);
    else
      met = $signed(req_q.value) < $signed(rd_rule_q.thr);
  end

  assign elapsed   = req_q.now_seconds - rd_time_q;
  assign rest_over = (rd_time_q == 32'd0) || (req_q.now_seconds < rd_time_q) ||
                     (elapsed >= {12'd0, mul_secs});
  assign last_rule = (idx_q + CntW'(1)) >= cnt_q;

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    found_d = found_q;
    fnd_d = fnd_q;
    echoed_d = echoed_q;
    pend_d = pend_q;
    raddr = idx_q[IdxW-1:0];
    we_rule = 1'b0;
    we_time = 1'b0;
    waddr = idx_q[IdxW-1:0];
    wrule = req_rule;
    wtime = '0;
    valid_d = 1'b0;
    res_d = '0;
    hold_d = hold_q;
    hold_v_d = hold_v_q;
    mul_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          idx_d = '0;
          fnd_d = 1'b0;
          echoed_d = 1'b0;
          if (req_i.operation == OpMeasure || req_i.operation == OpAdd ||
              req_i.operation == OpRemove) begin
            state_d = (cnt_q == '0) ? S_DONE : S_READ;
          end
        end
      end
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        if (req_q.operation == OpMeasure) begin
          if (rd_rule_q.sensor == req_q.sensor_id && in_win && met && req_q.route_ready) begin
            mul_start = 1'b1;
            state_d = S_MUL;
          end else begin
            idx_d = idx_q + CntW'(1);
            state_d = last_rule ? S_ECHO : S_READ;
          end
        end else begin
          if (rd_rule_q == req_rule && !fnd_q) begin
            fnd_d = 1'b1;
            found_d = idx_q[IdxW-1:0];
          end
          idx_d = idx_q + CntW'(1);
          state_d = last_rule ? S_DONE : S_READ;
        end
      end
      S_MUL: begin
        if (mul_done) state_d = S_REST;
      end
      S_REST: begin
        // the newest result waits in hold until it is known whether it is last
        if (rest_over) begin
          we_time = 1'b1;
          wtime = req_q.now_seconds;
          if (hold_v_q) begin
            valid_d = 1'b1;
            res_d = hold_q;
          end
          hold_d = '0;
          hold_d.kind = KindCommand;
          hold_d.out_command_id = rd_rule_q.cmd;
          hold_d.out_duration = rd_rule_q.dur;
          hold_v_d = 1'b1;
          if (!echoed_q) begin
            echoed_d = 1'b1;
            pend_d = 1'b1;
          end
        end
        idx_d = idx_q + CntW'(1);
        state_d = S_ECHO;
      end
      S_ECHO: begin
        // echo goes right after the first command; last set on final result
        if (pend_q) begin
          pend_d = 1'b0;
          if (hold_v_q) begin
            valid_d = 1'b1;
            res_d = hold_q;
          end
          hold_d = '0;
          hold_d.kind = KindEcho;
          hold_d.out_sensor_id = req_q.sensor_id;
          hold_d.out_value = req_q.value;
          hold_v_d = 1'b1;
        end else if (idx_q >= cnt_q) begin
          if (hold_v_q) begin
            valid_d = 1'b1;
            res_d = hold_q;
            res_d.last = 1'b1;
          end
          hold_v_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (req_q.operation == OpMeasure) begin
          state_d = S_IDLE;
        end else begin
          valid_d = 1'b1;
          res_d.kind = KindStatus;
          res_d.last = 1'b1;
          state_d = S_IDLE;
          if (req_q.operation == OpAdd) begin
            if (req_q.start_hour > LastHour || req_q.end_hour > LastHour ||
                req_q.rest_hours < min_q || req_q.rest_hours > max_q)
              res_d.status = StInvalid;
            else if (cnt_q >= CntW'(RuleSlots))
              res_d.status = StFull;
            else if (fnd_q)
              res_d.status = StDup;
            else begin
              res_d.status = StOk;
              we_rule = 1'b1;
              we_time = 1'b1;
              waddr = cnt_q[IdxW-1:0];
              wtime = '0;
              cnt_d = cnt_q + CntW'(1);
            end
          end else if (!fnd_q) begin
            res_d.status = StNotFound;
          end else begin
            valid_d = 1'b0;
            res_d = '0;
            idx_d = cnt_q - CntW'(1);
            state_d = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        raddr = idx_q[IdxW-1:0];
        state_d = S_WRITE;
      end
      S_WRITE: begin
        we_rule = 1'b1;
        we_time = 1'b1;
        waddr = found_q;
        wrule = rd_rule_q;
        wtime = rd_time_q;
        cnt_d = cnt_q - CntW'(1);
        valid_d = 1'b1;
        res_d.kind = KindStatus;
        res_d.status = StOk;
        res_d.last = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_rule_q <= rules_mem[raddr];
    rd_time_q <= time_mem[raddr];
    if (we_rule) rules_mem[waddr] <= wrule;
    if (we_time) time_mem[waddr] <= wtime;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      min_q <= 8'd1;
      max_q <= 8'd168;
      pend_q <= 1'b0;
      echoed_q <= 1'b0;
      fnd_q <= 1'b0;
      hold_v_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      pend_q <= pend_d;
      echoed_q <= echoed_d;
      fnd_q <= fnd_d;
      hold_v_q <= hold_v_d;
      valid_o <= valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgMinRest) min_q <= cfg_data_i;
        else max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    idx_q <= idx_d;
    found_q <= found_d;
    hold_q <= hold_d;
    res_o <= res_d;
  end

  assign busy = (state_q != S_IDLE);

  `include "threshold_rule_trigger_engine_assert.svh"
  `TRTE_ASSERT(a_count_bound, clk_i, rst_ni, cnt_q <= CntW'(RuleSlots))
  `TRTE_ASSERT(a_idle_quiet, clk_i, rst_ni, (state_q == S_IDLE) |=> !valid_o || $past(valid_d))
  `TRTE_ASSERT_NEVER(a_echo_idle, clk_i, rst_ni, pend_q && state_q == S_IDLE)
  `TRTE_ASSERT_NEVER(a_hold_idle, clk_i, rst_ni, hold_v_q && state_q == S_IDLE)
endmodule
